### design/sip_pkg.sv
// Shared types and constants of the splice_insert parser.
package sip_pkg;

	// Depth of the tag-seen memory: one entry per possible component tag.
	localparam int TAG_DEPTH = 256;
	localparam int TAG_W = $clog2(TAG_DEPTH);

	// Width of the command epoch that marks which command wrote a tag entry.
	localparam int EPOCH_W = 4;

	// Result queue between the parse stage and the output handshake.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam int PTS_W = 33;

	// Record kinds.
	localparam logic [2:0] KIND_EVENT = 3'd0;
	localparam logic [2:0] KIND_FLAGS = 3'd1;
	localparam logic [2:0] KIND_PTIME = 3'd2;
	localparam logic [2:0] KIND_COMPONENT = 3'd3;
	localparam logic [2:0] KIND_DURATION = 3'd4;
	localparam logic [2:0] KIND_TAIL = 3'd5;
	localparam logic [2:0] KIND_DONE = 3'd6;
	localparam logic [2:0] KIND_ERROR = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic first_byte;
		logic end_of_data;
	} cmd_t;

	typedef struct packed {
		logic [2:0] record_kind;
		logic [31:0] id_value;
		logic [3:0] flag_bits;
		logic [PTS_W-1:0] time_value;
		logic time_specified;
		logic duplicate_tag;
		logic [7:0] avail_number;
		logic [7:0] avails_total;
		logic [10:0] byte_length;
		logic last;
	} rec_t;

endpackage

### design/sip_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/splice_insert_parser.sv
// Streaming splice_insert parser: one command byte a cycle in, one record a cycle out, unless stalled.
// The parser takes one command byte per clock cycle on the cmd channel and returns records on
// the rec channel through the second stage and the result queue, one record per cycle unless
// rec_stall holds them. A byte that finishes two records at once (a canceled event with its done
// record, the tail with its done record, or any record followed by an early-end error) hands two
// records to an eight-entry result queue; cmd_stall rises only when that queue, together with the
// records still in flight, could not take two more, so a stream of bytes is held back only when
// the consumer falls behind. The byte rate is set by the single parse stage, whose state update
// and 33-bit PTS adjustment add are combinational. Repeated component tags are found through a
// 256-entry tag memory that stores, for each tag, the epoch of the command that last used it;
// a per-tag valid flag, cleared at reset and whenever the epoch wraps, makes entries from older
// commands read as unseen, so no clearing pass is needed and a new command starts at once.
// The user must write the PTS adjustment register through adj_wr_en and adj_wr_data only
// while the parser is idle; the block does not enforce it. A zero value leaves splice times unchanged.
module splice_insert_parser (
	input logic clk,
	input logic arst_n,
	input logic adj_wr_en,
	input logic [sip_pkg::PTS_W-1:0] adj_wr_data,
	input logic cmd_valid,
	output logic cmd_stall,
	input sip_pkg::cmd_t cmd_data,
	output logic rec_valid,
	input logic rec_stall,
	output sip_pkg::rec_t rec_data
);
	import sip_pkg::*;

	typedef enum logic [8:0] {
		PH_IDLE = 9'b000000001,
		PH_EVENT = 9'b000000010,
		PH_MODE = 9'b000000100,
		PH_PTIME = 9'b000001000,
		PH_COUNT = 9'b000010000,
		PH_CTAG = 9'b000100000,
		PH_CTIME = 9'b001000000,
		PH_DUR = 9'b010000000,
		PH_TAIL = 9'b100000000
	} phase_t;

	// Parse state, updated once per accepted byte.
	phase_t phase_q;
	logic [2:0] idx_q;
	logic [39:0] shift_q;
	logic [3:0] mode_q;
	logic [7:0] left_q;
	logic [7:0] tag_q;
	logic [10:0] count_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [PTS_W-1:0] adj_q;

	// Next-state values and the records the current byte completes.
	phase_t ph, ph_n;
	logic [2:0] idx, idx_n;
	logic [39:0] sh, sh_n;
	logic [3:0] md, md_n;
	logic [7:0] lf, lf_n;
	logic [7:0] tg, tg_n;
	logic [10:0] cnt;
	logic [EPOCH_W-1:0] ep;
	rec_t rec0, rec1;
	logic [1:0] n;
	logic comp;
	logic [TAG_W-1:0] comp_tag;
	logic st_done;
	logic st_spec;
	logic [PTS_W-1:0] st_time;
	logic [7:0] b;
	logic accept;
	logic fwd;

	// Second stage: records waiting for the duplicate-tag lookup.
	rec_t rec0_s1, rec1_s1;
	logic [1:0] n_s1;
	logic comp_s1;
	logic fwd_s1;
	logic [EPOCH_W-1:0] epoch_s1;
	logic [EPOCH_W-1:0] ram_epoch;
	logic [TAG_DEPTH-1:0] vld_q;
	logic dup_s1;
	rec_t rec0_dup;

	// Result queue.
	rec_t fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FIFO_AW:0] fcount_q;
	logic pop;
	logic [FIFO_AW:0] pending;

	function automatic phase_t after_components(input logic [3:0] flags);
		return flags[1] ? PH_DUR : PH_TAIL;
	endfunction

	// Room is reserved for the records in the second stage and two more from this byte.
	assign pending = fcount_q + {{(FIFO_AW-1){1'b0}}, n_s1};
	assign cmd_stall = pending > (FIFO_AW+1)'(FIFO_DEPTH - 2);
	assign accept = cmd_valid && !cmd_stall;
	assign b = cmd_data.data_byte;

	always_comb begin
		ph = phase_q;
		idx = idx_q;
		sh = shift_q;
		md = mode_q;
		lf = left_q;
		tg = tag_q;
		cnt = count_q;
		ep = epoch_q;
		if (cmd_data.first_byte) begin
			ph = PH_EVENT;
			idx = '0;
			sh = '0;
			md = '0;
			lf = '0;
			tg = '0;
			cnt = '0;
			ep = epoch_q + 1'b1;
		end
		if (ph != PH_IDLE) begin
			cnt = cnt + 1'b1;
			sh = {sh[31:0], b};
			idx = idx + 1'b1;
		end

		// A splice time is either a single byte with the time flag clear or five bytes.
		st_spec = !(idx == 3'd1 && !b[7]);
		st_done = !st_spec || idx >= 3'd5;
		st_time = st_spec ? sh[PTS_W-1:0] + adj_q : '0;

		ph_n = ph;
		idx_n = idx;
		sh_n = sh;
		md_n = md;
		lf_n = lf;
		tg_n = tg;
		rec0 = '0;
		rec1 = '0;
		n = 2'd0;
		comp = 1'b0;
		comp_tag = tg;

		unique case (ph)
			PH_IDLE: begin
			end
			PH_EVENT: begin
				if (idx >= 3'd5) begin
					rec0.record_kind = KIND_EVENT;
					rec0.id_value = sh[39:8];
					rec0.flag_bits = {3'b000, b[7]};
					n = 2'd1;
					if (b[7]) begin
						// A canceled event ends the command right here.
						rec1.record_kind = KIND_DONE;
						rec1.byte_length = cnt;
						rec1.last = 1'b1;
						n = 2'd2;
						ph_n = PH_IDLE;
					end else begin
						ph_n = PH_MODE;
					end
				end
			end
			PH_MODE: begin
				md_n = b[7:4];
				rec0.record_kind = KIND_FLAGS;
				rec0.flag_bits = md_n;
				n = 2'd1;
				if (md_n[2]) begin
					ph_n = md_n[0] ? after_components(md_n) : PH_PTIME;
				end else begin
					ph_n = PH_COUNT;
				end
			end
			PH_PTIME: begin
				if (st_done) begin
					rec0.record_kind = KIND_PTIME;
					rec0.time_value = st_time;
					rec0.time_specified = st_spec;
					n = 2'd1;
					ph_n = after_components(md);
				end
			end
			PH_COUNT: begin
				lf_n = b;
				ph_n = (b != 8'd0) ? PH_CTAG : after_components(md);
			end
			PH_CTAG: begin
				tg_n = b;
				if (md[0]) begin
					comp = 1'b1;
				end else begin
					ph_n = PH_CTIME;
				end
			end
			PH_CTIME: begin
				comp = st_done;
			end
			PH_DUR: begin
				if (idx >= 3'd5) begin
					rec0.record_kind = KIND_DURATION;
					rec0.flag_bits = {3'b000, sh[39]};
					rec0.time_value = sh[PTS_W-1:0];
					rec0.time_specified = 1'b1;
					n = 2'd1;
					ph_n = PH_TAIL;
				end
			end
			PH_TAIL: begin
				if (idx >= 3'd4) begin
					rec0.record_kind = KIND_TAIL;
					rec0.id_value = {16'h0000, sh[31:16]};
					rec0.avail_number = sh[15:8];
					rec0.avails_total = b;
					rec1.record_kind = KIND_DONE;
					rec1.byte_length = cnt;
					rec1.last = 1'b1;
					n = 2'd2;
					ph_n = PH_IDLE;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		if (comp) begin
			// In immediate mode the tag byte itself completes the component.
			comp_tag = tg_n;
			rec0.record_kind = KIND_COMPONENT;
			rec0.id_value = {24'h000000, tg_n};
			if (ph == PH_CTIME) begin
				rec0.time_value = st_time;
				rec0.time_specified = st_spec;
			end
			n = 2'd1;
			lf_n = lf - 1'b1;
			ph_n = (lf_n != 8'd0) ? PH_CTAG : after_components(md);
		end

		if (ph_n != ph) begin
			idx_n = '0;
			sh_n = '0;
		end

		// Bytes ran out before the command was complete.
		if (cmd_data.end_of_data && ph_n != PH_IDLE) begin
			if (n == 2'd0) begin
				rec0.record_kind = KIND_ERROR;
				rec0.last = 1'b1;
			end else begin
				rec1.record_kind = KIND_ERROR;
				rec1.last = 1'b1;
			end
			n = n + 1'b1;
			ph_n = PH_IDLE;
			idx_n = '0;
			sh_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q <= '0;
			shift_q <= '0;
			mode_q <= '0;
			left_q <= '0;
			tag_q <= '0;
			count_q <= '0;
			epoch_q <= '0;
			adj_q <= '0;
		end else begin
			if (adj_wr_en) begin
				adj_q <= adj_wr_data;
			end
			if (accept) begin
				phase_q <= ph_n;
				idx_q <= idx_n;
				shift_q <= sh_n;
				mode_q <= md_n;
				left_q <= lf_n;
				tag_q <= tg_n;
				count_q <= cnt;
				epoch_q <= ep;
			end
		end
	end

	// The previous component writes its tag entry in the same cycle as this lookup,
	// too late for the memory read; compare against it directly.
	assign fwd = comp_s1 && rec0_s1.id_value[TAG_W-1:0] == comp_tag && epoch_s1 == ep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_s1 <= 2'd0;
			comp_s1 <= 1'b0;
		end else begin
			n_s1 <= accept ? n : 2'd0;
			comp_s1 <= accept && comp;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec0_s1 <= rec0;
			rec1_s1 <= rec1;
			fwd_s1 <= fwd;
			epoch_s1 <= ep;
		end
	end

	sip_ram #(
		.WIDTH(EPOCH_W),
		.DEPTH(TAG_DEPTH)
	) u_tag_ram (
		.clk(clk),
		.wr_en(comp_s1),
		.wr_addr(rec0_s1.id_value[TAG_W-1:0]),
		.wr_data(epoch_s1),
		.rd_en(accept && comp),
		.rd_addr(comp_tag),
		.rd_data(ram_epoch)
	);

	// Valid flags are cleared when the epoch wraps, so a stale epoch can never match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			priority if (accept && cmd_data.first_byte && ep == '0) begin
				vld_q <= '0;
			end else if (comp_s1) begin
				vld_q[rec0_s1.id_value[TAG_W-1:0]] <= 1'b1;
			end
		end
	end

	assign dup_s1 = comp_s1 && (fwd_s1 ||
		(vld_q[rec0_s1.id_value[TAG_W-1:0]] && ram_epoch == epoch_s1));

	always_comb begin
		rec0_dup = rec0_s1;
		rec0_dup.duplicate_tag = dup_s1;
	end

	// Result queue.
	assign rec_valid = fcount_q != '0;
	assign rec_data = fifo_q[head_q];
	assign pop = rec_valid && !rec_stall;

	always_ff @(posedge clk) begin
		if (n_s1 != 2'd0) begin
			fifo_q[tail_q] <= rec0_dup;
		end
		if (n_s1 == 2'd2) begin
			fifo_q[tail_q + 1'b1] <= rec1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fcount_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			tail_q <= tail_q + FIFO_AW'(n_s1);
			fcount_q <= fcount_q + (FIFO_AW+1)'(n_s1) - (FIFO_AW+1)'(pop);
		end
	end

`ifndef SYNTH
	// The stall reservation must keep the queue from ever overflowing.
	assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	// A component lookup always carries a record into the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		comp_s1 |-> n_s1 != 2'd0)
		else $error("component lookup without a record");

	// Only done and error records close a command.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.last |->
		rec_data.record_kind == KIND_DONE || rec_data.record_kind == KIND_ERROR)
		else $error("last flag on a record that does not end a command");

	// Two records from one byte always end the command.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && n == 2'd2 |=> phase_q == PH_IDLE)
		else $error("parser still open after a closing record pair");
`endif

endmodule
